// ===== hw/rtl/qrmu_pkg.sv =====
// Shared types and constants of the quaternion rotate/multiply unit.
// Used by every pipeline module and by the port checker; depends on nothing.

package qrmu_pkg;

  // Operation codes as seen on in_func.
  localparam logic [2:0] FUNC_ROT   = 3'd0;
  localparam logic [2:0] FUNC_IROT  = 3'd1;
  localparam logic [2:0] FUNC_AB    = 3'd2;
  localparam logic [2:0] FUNC_BA    = 3'd3;
  localparam logic [2:0] FUNC_DERIV = 3'd4;

  localparam int WORD_W = 32;
  localparam int PROD_W = 64;              // one component product
  localparam int SUM_W  = 66;              // sum of four products, matrix entries
  localparam int HALF_W = 33;              // low slice of a matrix entry
  localparam int LO_W   = HALF_W + 1 + WORD_W;
  localparam int HI_W   = SUM_W - HALF_W + WORD_W;
  localparam int MV_W   = 98;              // matrix entry times vector component
  localparam int ACC_W  = 100;             // final exact component

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [LO_W-1:0]   lo_t;
  typedef logic signed [HI_W-1:0]   hi_t;
  typedef logic signed [MV_W-1:0]   mv_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    MODE_ROT,
    MODE_HAM,
    MODE_DERIV,
    MODE_NONE
  } mode_t;

  // Control that travels down the pipeline with each request.
  typedef struct packed {
    logic  valid;
    mode_t mode;
    logic  flip;   // inverse rotation, or operand order b*a
  } ctl_t;

endpackage

// ===== hw/rtl/qrmu_mult.sv =====
// First pipeline stage: operand selection and the bank of sixteen 32x32 products.
// Depends on qrmu_pkg.

module qrmu_mult
  import qrmu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  logic [2:0] func,
  input  word_t a [4],
  input  word_t b [4],
  output ctl_t  ctl,
  output prod_t p [16],
  output word_t v [3]
);

  ctl_t  ctl_r, ctl_nxt;
  prod_t p_r [16];
  prod_t p_nxt [16];
  word_t v_r [3];
  word_t y [4];

  always_comb begin
    ctl_nxt.valid = accept;
    ctl_nxt.flip  = 1'b0;
    case (func)
      FUNC_ROT: begin
        ctl_nxt.mode = MODE_ROT;
      end
      FUNC_IROT: begin
        ctl_nxt.mode = MODE_ROT;
        ctl_nxt.flip = 1'b1;
      end
      FUNC_AB: begin
        ctl_nxt.mode = MODE_HAM;
      end
      FUNC_BA: begin
        ctl_nxt.mode = MODE_HAM;
        ctl_nxt.flip = 1'b1;
      end
      FUNC_DERIV: begin
        ctl_nxt.mode = MODE_DERIV;
      end
      default: begin
        ctl_nxt.mode = MODE_NONE;
      end
    endcase
  end

  // Rotations square a with itself; the derivative treats b as a pure vector.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      y[i] = (ctl_nxt.mode == MODE_ROT) ? a[i] : b[i];
    end
    if (ctl_nxt.mode == MODE_DERIV) begin
      y[0] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_nxt[i*4+j] = a[i] * y[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    for (int i = 0; i < 3; i++) begin
      v_r[i] <= b[i+1];
    end
  end

  assign ctl = ctl_r;
  assign p   = p_r;
  assign v   = v_r;

endmodule

// ===== hw/rtl/qrmu_comb.sv =====
// Second pipeline stage: sums the products into the nine rotation-matrix entries
// and the four Hamilton product components. Depends on qrmu_pkg.

module qrmu_comb
  import qrmu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl_in,
  input  prod_t p [16],
  input  word_t v_in [3],
  output ctl_t  ctl,
  output sum_t  coef [9],
  output sum_t  hsum [4],
  output word_t v [3]
);

  ctl_t  ctl_r;
  sum_t  coef_r [9];
  sum_t  coef_nxt [9];
  sum_t  hsum_r [4];
  sum_t  hsum_nxt [4];
  word_t v_r [3];

  // Entry e[i*4+j] is the product of a component i with operand component j.
  always_comb begin
    sum_t e [16];
    sum_t q01, q02, q03;
    sum_t c12, c23, c31;
    for (int k = 0; k < 16; k++) begin
      e[k] = SUM_W'(p[k]);
    end
    // The inverse rotation is the transpose: the terms that pair w with a
    // vector component change sign.
    q01 = ctl_in.flip ? -e[1] : e[1];
    q02 = ctl_in.flip ? -e[2] : e[2];
    q03 = ctl_in.flip ? -e[3] : e[3];

    coef_nxt[0] = e[0] + e[5] - e[10] - e[15];
    coef_nxt[1] = (e[6] - q03) <<< 1;
    coef_nxt[2] = (e[7] + q02) <<< 1;
    coef_nxt[3] = (e[6] + q03) <<< 1;
    coef_nxt[4] = e[0] - e[5] + e[10] - e[15];
    coef_nxt[5] = (e[11] - q01) <<< 1;
    coef_nxt[6] = (e[7] - q02) <<< 1;
    coef_nxt[7] = (e[11] + q01) <<< 1;
    coef_nxt[8] = e[0] - e[5] - e[10] + e[15];

    // Swapping the operands only flips the sign of the cross-product terms.
    c23 = e[11] - e[14];
    c31 = e[13] - e[7];
    c12 = e[6] - e[9];
    hsum_nxt[0] = e[0] - e[5] - e[10] - e[15];
    hsum_nxt[1] = e[1] + e[4] + (ctl_in.flip ? -c23 : c23);
    hsum_nxt[2] = e[2] + e[8] + (ctl_in.flip ? -c31 : c31);
    hsum_nxt[3] = e[3] + e[12] + (ctl_in.flip ? -c12 : c12);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    hsum_r <= hsum_nxt;
    v_r    <= v_in;
  end

  assign ctl  = ctl_r;
  assign coef = coef_r;
  assign hsum = hsum_r;
  assign v    = v_r;

endmodule

// ===== hw/rtl/qrmu_mvec.sv =====
// Third and fourth pipeline stages: matrix entries times vector components,
// each split into two narrow partial products that are merged a stage later.
// Depends on qrmu_pkg.

module qrmu_mvec
  import qrmu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl_in,
  input  sum_t  coef [9],
  input  sum_t  hsum_in [4],
  input  word_t v [3],
  output ctl_t  ctl,
  output mv_t   prod [9],
  output sum_t  hsum [4]
);

  ctl_t ctl1_r, ctl2_r;
  lo_t  lo_r [9];
  lo_t  lo_nxt [9];
  hi_t  hi_r [9];
  hi_t  hi_nxt [9];
  mv_t  prod_r [9];
  mv_t  prod_nxt [9];
  sum_t hsum1_r [4];
  sum_t hsum2_r [4];

  // Entry k = row*3 + col multiplies vector component col.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lo_nxt[r*3+c] = $signed({1'b0, coef[r*3+c][HALF_W-1:0]}) * v[c];
        hi_nxt[r*3+c] = $signed(coef[r*3+c][SUM_W-1:HALF_W]) * v[c];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_nxt[k] = (MV_W'(hi_r[k]) <<< HALF_W) + MV_W'(lo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    hsum1_r <= hsum_in;
    prod_r  <= prod_nxt;
    hsum2_r <= hsum1_r;
  end

  assign ctl  = ctl2_r;
  assign prod = prod_r;
  assign hsum = hsum2_r;

endmodule

// ===== hw/rtl/qrmu_out.sv =====
// Fifth and sixth pipeline stages: row sums of the rotation, selection of the
// exact component per operation, then rounding and saturation into the output
// registers. Depends on qrmu_pkg.

module qrmu_out
  import qrmu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl_in,
  input  mv_t   prod [9],
  input  sum_t  hsum [4],
  output logic  res_valid,
  output word_t res [4],
  output logic  res_sat
);

  localparam int SHIFT_ROT   = 60;
  localparam int SHIFT_HAM   = 30;
  localparam int SHIFT_DERIV = 31;
  localparam int RND_W       = ACC_W - SHIFT_HAM;

  typedef logic signed [RND_W-1:0] rnd_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } rnd_res_t;

  ctl_t     ctl_r;
  acc_t     acc_r [4];
  acc_t     acc_nxt [4];
  logic     valid_r;
  word_t    res_r [4];
  word_t    res_nxt [4];
  logic     sat_r, sat_nxt;
  rnd_res_t rr [4];

  // Round to nearest with ties upward, then clamp to the signed word range.
  function automatic rnd_res_t round_sat(acc_t acc, mode_t mode);
    acc_t     t;
    rnd_t     q;
    rnd_res_t o;
    case (mode)
      MODE_ROT: begin
        t = acc + (acc_t'(1) <<< (SHIFT_ROT - 1));
        q = rnd_t'(t >>> SHIFT_ROT);
      end
      MODE_DERIV: begin
        t = acc + (acc_t'(1) <<< (SHIFT_DERIV - 1));
        q = rnd_t'(t >>> SHIFT_DERIV);
      end
      default: begin
        t = acc + (acc_t'(1) <<< (SHIFT_HAM - 1));
        q = rnd_t'(t >>> SHIFT_HAM);
      end
    endcase
    if ((&q[RND_W-1:WORD_W-1]) || !(|q[RND_W-1:WORD_W-1])) begin
      o.sat = 1'b0;
      o.val = q[WORD_W-1:0];
    end else begin
      o.sat = 1'b1;
      o.val = q[RND_W-1] ? WORD_MIN : WORD_MAX;
    end
    return o;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_nxt[i] = '0;
    end
    case (ctl_in.mode)
      MODE_ROT: begin
        for (int r = 0; r < 3; r++) begin
          acc_nxt[r+1] = ACC_W'(prod[r*3]) + ACC_W'(prod[r*3+1]) + ACC_W'(prod[r*3+2]);
        end
      end
      MODE_HAM, MODE_DERIV: begin
        for (int i = 0; i < 4; i++) begin
          acc_nxt[i] = ACC_W'(hsum[i]);
        end
      end
      default: begin
        // Unknown codes leave every component at zero.
        for (int i = 0; i < 4; i++) begin
          acc_nxt[i] = '0;
        end
      end
    endcase
  end

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      rr[i]      = round_sat(acc_r[i], ctl_r.mode);
      res_nxt[i] = rr[i].val;
      sat_nxt    = sat_nxt | rr[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      ctl_r   <= ctl_in;
      valid_r <= ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    sat_r <= sat_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;
  assign res_sat   = sat_r;

endmodule

// ===== hw/rtl/quaternion_rotate_multiply_unit.sv =====
// Top level of the quaternion rotate/multiply unit: six pipeline stages.
// Depends on qrmu_pkg, qrmu_mult, qrmu_comb, qrmu_mvec and qrmu_out.
//
// The unit takes one request in every clock cycle: busy is never asserted, so
// each cycle with start high is an accepted request. Its result appears on the
// out_ ports once it has passed every stage, marked by a one-cycle out_valid
// strobe, and results leave in request order. The stages are the multiplier
// bank, the product sums, the split matrix-times-vector multiply and its merge,
// the row sums, and the rounding with saturation. The receiver cannot stall the
// unit, so it must take every strobed result. Codes 0 and 1 rotate the Q16.16
// vector (b_x, b_y, b_z) by a or by its inverse, 2 and 3 give a*b and b*a in
// Q2.30, 4 gives 0.5*a*(0,b) in Q16.16; other codes return zero. out_saturated
// flags that at least one component was clamped.

module quaternion_rotate_multiply_unit
  import qrmu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  output logic               out_valid,
  output logic signed [31:0] out_res_w,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [31:0] out_res_z,
  output logic               out_saturated
);

  word_t a [4];
  word_t b [4];
  ctl_t  ctl1, ctl2, ctl4;
  prod_t p [16];
  word_t v1 [3];
  word_t v2 [3];
  sum_t  coef [9];
  sum_t  hsum2 [4];
  sum_t  hsum4 [4];
  mv_t   prod [9];
  word_t res [4];
  logic  accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign a[0] = in_a_w;
  assign a[1] = in_a_x;
  assign a[2] = in_a_y;
  assign a[3] = in_a_z;
  assign b[0] = in_b_w;
  assign b[1] = in_b_x;
  assign b[2] = in_b_y;
  assign b[3] = in_b_z;

  qrmu_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .func   (in_func),
    .a      (a),
    .b      (b),
    .ctl    (ctl1),
    .p      (p),
    .v      (v1)
  );

  qrmu_comb u_comb (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (ctl1),
    .p      (p),
    .v_in   (v1),
    .ctl    (ctl2),
    .coef   (coef),
    .hsum   (hsum2),
    .v      (v2)
  );

  qrmu_mvec u_mvec (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl2),
    .coef    (coef),
    .hsum_in (hsum2),
    .v       (v2),
    .ctl     (ctl4),
    .prod    (prod),
    .hsum    (hsum4)
  );

  qrmu_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl4),
    .prod      (prod),
    .hsum      (hsum4),
    .res_valid (out_valid),
    .res       (res),
    .res_sat   (out_saturated)
  );

  assign out_res_w = res[0];
  assign out_res_x = res[1];
  assign out_res_y = res[2];
  assign out_res_z = res[3];

endmodule

// ===== hw/rtl/qrmu_chk.sv =====
// Port-level checker for the quaternion rotate/multiply unit and its bind.
// Depends on qrmu_pkg and on the top level's port names.

module qrmu_chk
  import qrmu_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [2:0]         in_func,
  input logic               out_valid,
  input logic signed [31:0] out_res_w,
  input logic signed [31:0] out_res_x,
  input logic signed [31:0] out_res_y,
  input logic signed [31:0] out_res_z,
  input logic               out_saturated
);

  // Every accepted request produces exactly one result at the pipeline output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("request without result after six cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result without a matching request");

  a_rot_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_ROT || in_func == FUNC_IROT))
      |-> ##6 (out_res_w == '0))
    else $error("rotation result has a nonzero scalar part");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func > FUNC_DERIV)
      |-> ##6 (out_res_w == '0 && out_res_x == '0 && out_res_y == '0
               && out_res_z == '0 && !out_saturated))
    else $error("unknown operation code gave a nonzero result");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated)
      |-> (out_res_w == WORD_MAX || out_res_w == WORD_MIN
           || out_res_x == WORD_MAX || out_res_x == WORD_MIN
           || out_res_y == WORD_MAX || out_res_y == WORD_MIN
           || out_res_z == WORD_MAX || out_res_z == WORD_MIN))
    else $error("saturation flagged but no component sits at a limit");

endmodule

bind quaternion_rotate_multiply_unit qrmu_chk u_chk (.*);

// ===== bench/tb_quaternion_rotate_multiply_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for quaternion_rotate_multiply_unit: a directed table, then random
// requests, checked against typed-in rows or an exact wide-integer model. Depends on qrmu_pkg and the RTL.

module tb_quaternion_rotate_multiply_unit
  import qrmu_pkg::*;
();

  localparam logic [2:0] FUNC_RSV5 = 3'd5;
  localparam logic [2:0] FUNC_RSV6 = 3'd6;
  localparam logic [2:0] FUNC_RSV7 = 3'd7;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] MX      = WORD_MAX;
  localparam logic [31:0] MN      = WORD_MIN;

  localparam int RANDOM_PER_PHASE = 410;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 12;

  typedef logic signed [127:0] wide_t;

  localparam wide_t LIM_HI = 128'sh7FFF_FFFF;
  localparam wide_t LIM_LO = -LIM_HI - 1;

  // Component 0 is w, then x, y, z.
  typedef struct packed {
    logic [2:0]       func;
    logic [3:0][31:0] a;
    logic [3:0][31:0] b;
  } quat_req_t;

  typedef struct packed {
    logic [3:0][31:0] r;
    logic             sat;
  } quat_res_t;

  typedef struct packed {
    quat_req_t rq;
    logic      chk;
    quat_res_t ex;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_func;
  logic signed [31:0] in_a_w, in_a_x, in_a_y, in_a_z;
  logic signed [31:0] in_b_w, in_b_x, in_b_y, in_b_z;
  logic               out_valid;
  logic signed [31:0] out_res_w, out_res_x, out_res_y, out_res_z;
  logic               out_saturated;

  // Typed-in expectation that travels with the request on the pins.
  logic               dir_chk;
  quat_res_t          dir_exp;

  quat_res_t pending_results[$];
  dir_row_t  dir_rows[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        func_seen [8];
  int        sat_seen = 0;
  int        result_count = 0;
  string     fld_name [4] = '{"res_w", "res_x", "res_y", "res_z"};

  quaternion_rotate_multiply_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_a_w       (in_a_w),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_a_z       (in_a_z),
    .in_b_w       (in_b_w),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_b_z       (in_b_z),
    .out_valid    (out_valid),
    .out_res_w    (out_res_w),
    .out_res_x    (out_res_x),
    .out_res_y    (out_res_y),
    .out_res_z    (out_res_z),
    .out_saturated(out_saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact sums in 128 bits, one rounding (half up) and a clamp per component.
  function automatic quat_res_t quat_unit_predict(input quat_req_t rq);
    wide_t     a [4];
    wide_t     v [4];
    wide_t     p [4];
    wide_t     q [4];
    wide_t     m [4][4];
    wide_t     acc [4];
    wide_t     g;
    wide_t     half;
    wide_t     t;
    int        sh;
    bit        ham;
    quat_res_t rs;
    for (int i = 0; i < 4; i++) begin
      a[i] = $signed(rq.a[i]);
      v[i] = $signed(rq.b[i]);
      acc[i] = 0;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        m[i][j] = a[i] * a[j];
    sh = 0;
    ham = 1'b0;
    g = 1;
    p = a;
    q = v;
    case (rq.func)
      FUNC_ROT, FUNC_IROT: begin
        if (rq.func == FUNC_IROT) g = -1;
        acc[1] = (m[0][0] + m[1][1] - m[2][2] - m[3][3]) * v[1]
               + 2 * (m[1][2] - g * m[0][3]) * v[2]
               + 2 * (g * m[0][2] + m[1][3]) * v[3];
        acc[2] = 2 * (g * m[0][3] + m[1][2]) * v[1]
               + (m[0][0] - m[1][1] + m[2][2] - m[3][3]) * v[2]
               + 2 * (m[2][3] - g * m[0][1]) * v[3];
        acc[3] = 2 * (m[1][3] - g * m[0][2]) * v[1]
               + 2 * (g * m[0][1] + m[2][3]) * v[2]
               + (m[0][0] - m[1][1] - m[2][2] + m[3][3]) * v[3];
        sh = 60;
      end
      FUNC_AB: begin
        ham = 1'b1;
        sh = 30;
      end
      FUNC_BA: begin
        p = v;
        q = a;
        ham = 1'b1;
        sh = 30;
      end
      FUNC_DERIV: begin
        // The angular velocity is a pure quaternion; the extra bit of shift is the 0.5.
        q[0] = 0;
        ham = 1'b1;
        sh = 31;
      end
      default: ;
    endcase
    if (ham) begin
      acc[0] = p[0] * q[0] - p[1] * q[1] - p[2] * q[2] - p[3] * q[3];
      acc[1] = p[0] * q[1] + p[1] * q[0] + p[2] * q[3] - p[3] * q[2];
      acc[2] = p[0] * q[2] + p[2] * q[0] + p[3] * q[1] - p[1] * q[3];
      acc[3] = p[0] * q[3] + p[3] * q[0] + p[1] * q[2] - p[2] * q[1];
    end
    rs = '0;
    for (int i = 0; i < 4; i++) begin
      if (sh != 0) begin
        half = 1;
        half = half <<< (sh - 1);
        t = (acc[i] + half) >>> sh;
        if (t > LIM_HI) begin
          rs.r[i] = WORD_MAX;
          rs.sat = 1'b1;
        end else if (t < LIM_LO) begin
          rs.r[i] = WORD_MIN;
          rs.sat = 1'b1;
        end else begin
          rs.r[i] = t[31:0];
        end
      end
    end
    return rs;
  endfunction

  // Mostly raw or scaled-down values, with the extremes mixed in.
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        case (w[1:0])
          2'd0: w = MX;
          2'd1: w = MN;
          2'd2: w = '0;
          default: w = '1;
        endcase
      end
      1, 2: ;
      default: w = $signed(w) >>> $urandom_range(1, 24);
    endcase
    return w;
  endfunction

  function automatic quat_req_t rand_request();
    quat_req_t rq;
    if ($urandom_range(0, 15) == 0)
      rq.func = 3'($urandom_range(FUNC_RSV5, FUNC_RSV7));
    else
      rq.func = 3'($urandom_range(FUNC_ROT, FUNC_DERIV));
    for (int i = 0; i < 4; i++) begin
      rq.a[i] = rand_word();
      rq.b[i] = rand_word();
    end
    if (rq.func != FUNC_AB && rq.func != FUNC_BA && $urandom_range(0, 19) == 0)
      rq.b[3:1] = '0;
    return rq;
  endfunction

  task automatic add_dir(input logic [2:0] f,
                         input logic [31:0] aw, ax, ay, az, bw, bx, by, bz,
                         input logic chk,
                         input logic [31:0] ew, ex, ey, ez, input logic es);
    dir_row_t row;
    row.rq.func = f;
    row.rq.a = {az, ay, ax, aw};
    row.rq.b = {bz, by, bx, bw};
    row.chk = chk;
    row.ex.r = {ez, ey, ex, ew};
    row.ex.sat = es;
    dir_rows.push_back(row);
  endtask

  task automatic issue_request(input quat_req_t rq, input logic chk, input quat_res_t ex);
    @(negedge clk);
    start   <= 1'b1;
    in_func <= rq.func;
    in_a_w  <= rq.a[0];
    in_a_x  <= rq.a[1];
    in_a_y  <= rq.a[2];
    in_a_z  <= rq.a[3];
    in_b_w  <= rq.b[0];
    in_b_x  <= rq.b[1];
    in_b_y  <= rq.b[2];
    in_b_z  <= rq.b[3];
    dir_chk <= chk;
    dir_exp <= ex;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Scoreboard: results are compared first, then the request on the pins is recorded.
  always @(posedge clk) begin : monitor
    quat_req_t rq;
    quat_res_t got;
    quat_res_t want;
    bit        moved;
    if (rst_n === 1'b1) begin
      moved = 1'b0;
      if (out_valid === 1'b1) begin
        moved = 1'b1;
        result_count++;
        got.r = {out_res_z, out_res_y, out_res_x, out_res_w};
        got.sat = out_saturated;
        sat_seen += (out_saturated === 1'b1);
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request waiting", $time);
        end else begin
          want = pending_results.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got.r[i] !== want.r[i]) begin
              fail_count++;
              $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, fld_name[i],
                       $signed(want.r[i]), want.r[i], $signed(got.r[i]), got.r[i]);
            end
          end
          if (got.sat !== want.sat) begin
            fail_count++;
            $display("%0t: saturated expected %b got %b", $time, want.sat, got.sat);
          end
        end
      end else if (out_valid !== 1'b0) begin
        fail_count++;
        $display("%0t: out_valid expected 0 or 1 got %b", $time, out_valid);
      end
      if (start === 1'b1 && busy === 1'b0) begin
        moved = 1'b1;
        rq.func = in_func;
        rq.a = {in_a_z, in_a_y, in_a_x, in_a_w};
        rq.b = {in_b_z, in_b_y, in_b_x, in_b_w};
        func_seen[rq.func]++;
        if (dir_chk)
          pending_results.push_back(dir_exp);
        else
          pending_results.push_back(quat_unit_predict(rq));
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int        idle_pct [4] = '{0, 66, 0, 9};
    quat_res_t none;
    none = '0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_func = '0;
    in_a_w  = '0;
    in_a_x  = '0;
    in_a_y  = '0;
    in_a_z  = '0;
    in_b_w  = '0;
    in_b_x  = '0;
    in_b_y  = '0;
    in_b_z  = '0;
    dir_chk = 1'b0;
    dir_exp = '0;
    for (int i = 0; i < 8; i++) func_seen[i] = 0;

    // Zero vectors give zero whatever a is; b_w is ignored by these codes.
    add_dir(FUNC_ROT, 32'h1234_5678, 32'h0ABC_DEF0, -32'sd5, MN, MX, 0, 0, 0,
            1, 0, 0, 0, 0, 0);
    add_dir(FUNC_IROT, MN, MN, MN, MN, MN, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_dir(FUNC_DERIV, MX, MX, MX, MX, MX, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // The identity quaternion passes the operand through.
    add_dir(FUNC_ROT, ONE_Q30, 0, 0, 0, MX, 32'h0001_0000, 32'hFFFE_0000, MX,
            1, 0, 32'h0001_0000, 32'hFFFE_0000, MX, 0);
    add_dir(FUNC_IROT, ONE_Q30, 0, 0, 0, 0, MN, MN, MN, 1, 0, MN, MN, MN, 0);
    add_dir(FUNC_AB, ONE_Q30, 0, 0, 0, MX, MN, 1, '1, 1, MX, MN, 1, '1, 0);
    add_dir(FUNC_BA, MN, MX, '1, 0, ONE_Q30, 0, 0, 0, 1, MN, MX, '1, 0, 0);
    // Most negative operands overflow every product component.
    add_dir(FUNC_AB, MN, MN, MN, MN, MN, MN, MN, MN, 1, MN, MX, MX, MX, 1);
    add_dir(FUNC_BA, MN, MN, MN, MN, MN, MN, MN, MN, 1, MN, MX, MX, MX, 1);
    add_dir(FUNC_RSV5, MX, MX, MX, MX, MX, MX, MX, MX, 1, 0, 0, 0, 0, 0);
    add_dir(FUNC_RSV6, MN, MN, MN, MN, MN, MN, MN, MN, 1, 0, 0, 0, 0, 0);
    add_dir(FUNC_RSV7, MX, MN, MX, MN, MX, MN, MX, MN, 1, 0, 0, 0, 0, 0);
    // Halving ties round toward plus infinity.
    add_dir(FUNC_DERIV, ONE_Q30, 0, 0, 0, MX, 3, -32'sd3, 32'h0002_0000,
            1, 0, 2, '1, 32'h0001_0000, 0);
    add_dir(FUNC_ROT, MX, MX, MX, MX, MX, MX, MX, MX, 0, 0, 0, 0, 0, 0);
    add_dir(FUNC_ROT, MN, MN, MN, MN, MN, MN, MN, MN, 0, 0, 0, 0, 0, 0);
    add_dir(FUNC_IROT, MX, MN, MX, MN, 0, MX, MN, 1, 0, 0, 0, 0, 0, 0);
    add_dir(FUNC_AB, MX, MX, MX, MX, MX, MX, MX, MX, 0, 0, 0, 0, 0, 0);
    add_dir(FUNC_DERIV, MN, MN, MN, MN, MN, MN, MN, MN, 0, 0, 0, 0, 0, 0);
    add_dir(FUNC_IROT, 32'h2000_0000, 32'hE000_0000, 32'h2000_0000, 32'h2000_0000,
            0, 32'h0003_8000, 32'hFFFF_0001, 32'h0100_0000, 0, 0, 0, 0, 0, 0);
    add_dir(FUNC_BA, 32'h3A00_1234, 32'hC123_4567, 32'h0000_0001, 32'hFFFF_FFFF,
            32'h8000_0001, 32'h7FFF_FFFE, 32'h1111_1111, 32'hEEEE_EEEE, 0, 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      issue_request(dir_rows[i].rq, dir_rows[i].chk, dir_rows[i].ex);

    // The receiver cannot hold results off, so only the sender idles.
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        while ($urandom_range(0, 99) < idle_pct[ph]) idle_cycle();
        issue_request(rand_request(), 1'b0, none);
      end
    end
    idle_cycle();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: rotate %0d, inverse %0d, a*b %0d, b*a %0d, deriv %0d,",
             func_seen.sum(), func_seen[FUNC_ROT], func_seen[FUNC_IROT], func_seen[FUNC_AB],
             func_seen[FUNC_BA], func_seen[FUNC_DERIV]);
    $display("reserved codes %0d; %0d results checked, %0d of them clamped, %0d mismatches.",
             func_seen[FUNC_RSV5] + func_seen[FUNC_RSV6] + func_seen[FUNC_RSV7],
             result_count, sat_seen, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== quaternion_rotate_multiply_unit.f =====
hw/rtl/qrmu_pkg.sv
hw/rtl/qrmu_mult.sv
hw/rtl/qrmu_comb.sv
hw/rtl/qrmu_mvec.sv
hw/rtl/qrmu_out.sv
hw/rtl/quaternion_rotate_multiply_unit.sv
hw/rtl/qrmu_chk.sv
bench/tb_quaternion_rotate_multiply_unit.sv
